>>> design/lmlt_pkg.sv
`default_nettype none

package lmlt_pkg;

	localparam int DOT_W  = 10;
	localparam int LINE_W = 8;
	localparam int CYC_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam int DEF_OAM_END       = 80;
	localparam int DEF_TRANSFER_END  = 252;
	localparam int DEF_LINE_PERIOD   = 456;
	localparam int DEF_VISIBLE_LINES = 144;
	localparam int DEF_LAST_LINE     = 153;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} lmlt_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LYC_VALUE     = 3'd0,
		CFG_HBLANK_IRQ_EN = 3'd1,
		CFG_VBLANK_IRQ_EN = 3'd2,
		CFG_OAM_IRQ_EN    = 3'd3,
		CFG_LYC_IRQ_EN    = 3'd4
	} lmlt_cfg_idx_t;

	typedef struct packed {
		logic [LINE_W-1:0] lyc_value;
		logic              hblank_irq_en;
		logic              vblank_irq_en;
		logic              oam_irq_en;
		logic              lyc_irq_en;
	} lmlt_cfg_t;

	typedef struct packed {
		lmlt_mode_t        mode;
		logic [LINE_W-1:0] line;
		logic              coincidence;
		logic              lcd_irq;
		logic              vblank_irq;
		logic              draw_request;
		logic [LINE_W-1:0] draw_index;
	} lmlt_result_t;

endpackage

`default_nettype wire

>>> design/lmlt_if.sv
`default_nettype none

interface lmlt_item_if;
	import lmlt_pkg::*;
	logic              valid;
	logic              ready;
	logic [CYC_W-1:0]  cycles;
	logic              lcd_enable;

	modport source (output valid, output cycles, output lcd_enable, input ready);
	modport sink (input valid, input cycles, input lcd_enable, output ready);
endinterface

interface lmlt_result_if;
	import lmlt_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [LINE_W-1:0] line;
	logic              coincidence;
	logic              lcd_irq;
	logic              vblank_irq;
	logic              draw_request;
	logic [LINE_W-1:0] draw_index;

	modport source (output valid, output mode, output line, output coincidence,
		output lcd_irq, output vblank_irq, output draw_request, output draw_index,
		input ready);
	modport sink (input valid, input mode, input line, input coincidence,
		input lcd_irq, input vblank_irq, input draw_request, input draw_index,
		output ready);
endinterface

interface lmlt_cfg_if;
	import lmlt_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> design/lmlt_cfg.sv
`default_nettype none

module lmlt_cfg
	import lmlt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output lmlt_cfg_t                  cfg
);

	lmlt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_LYC_VALUE:     cfg_q.lyc_value     <= wr_data[LINE_W-1:0];
				CFG_HBLANK_IRQ_EN: cfg_q.hblank_irq_en <= wr_data[0];
				CFG_VBLANK_IRQ_EN: cfg_q.vblank_irq_en <= wr_data[0];
				CFG_OAM_IRQ_EN:    cfg_q.oam_irq_en    <= wr_data[0];
				CFG_LYC_IRQ_EN:    cfg_q.lyc_irq_en    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> design/lmlt_step.sv
`default_nettype none

module lmlt_step
	import lmlt_pkg::*;
#(
	parameter int OAM_END       = DEF_OAM_END,
	parameter int TRANSFER_END  = DEF_TRANSFER_END,
	parameter int LINE_PERIOD   = DEF_LINE_PERIOD,
	parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
	parameter int LAST_LINE     = DEF_LAST_LINE
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [CYC_W-1:0] cycles,
	input  wire logic             lcd_enable,
	input  wire lmlt_cfg_t        cfg,
	output lmlt_result_t          result
);

	logic [DOT_W-1:0]  dot_q, dot_n, dot_sum;
	logic [LINE_W-1:0] line_q, line_n, line_base;
	lmlt_mode_t        mode_q, mode_n;
	logic              coin_q, coin_n;
	logic              changed, sel, line_end;

	always_comb begin
		dot_sum   = dot_q + DOT_W'(cycles);
		dot_n     = dot_sum;
		line_n    = line_q;
		line_base = line_q;
		mode_n    = mode_q;
		changed   = 1'b0;
		sel       = 1'b0;
		line_end  = 1'b0;
		result    = '0;
		if (!lcd_enable) begin
			dot_n  = '0;
			line_n = '0;
			mode_n = MODE_HBLANK;
			coin_n = coin_q;
		end else begin
			if (dot_sum < DOT_W'(OAM_END)) begin
				mode_n = MODE_OAM;
				sel    = cfg.oam_irq_en;
			end else if (dot_sum < DOT_W'(TRANSFER_END)) begin
				mode_n = MODE_XFER;
			end else if (dot_sum < DOT_W'(LINE_PERIOD)) begin
				mode_n = MODE_HBLANK;
				sel    = cfg.hblank_irq_en;
			end else begin
				line_end = 1'b1;
			end
			if (line_end) begin
				// Past the last line the counter restarts from zero, so it steps to one, and line zero is drawn.
				if (line_q > LINE_W'(LAST_LINE)) begin
					line_base           = '0;
					result.draw_request = 1'b1;
				end else if (line_q == LINE_W'(VISIBLE_LINES)) begin
					mode_n            = MODE_VBLANK;
					sel               = cfg.vblank_irq_en;
					result.vblank_irq = 1'b1;
				end else if (line_q < LINE_W'(VISIBLE_LINES)) begin
					result.draw_request = 1'b1;
					result.draw_index   = line_q;
				end
				dot_n  = dot_sum - DOT_W'(LINE_PERIOD);
				line_n = line_base + LINE_W'(1);
			end
			changed = (mode_n != mode_q);
			coin_n  = (line_n != '0) && ((line_n - LINE_W'(1)) == cfg.lyc_value);
			result.lcd_irq = (changed && sel) || (coin_n && cfg.lyc_irq_en);
		end
		result.mode        = mode_n;
		result.line        = line_n;
		result.coincidence = coin_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q  <= '0;
			line_q <= '0;
			mode_q <= MODE_HBLANK;
			coin_q <= 1'b0;
		end else if (advance) begin
			dot_q  <= dot_n;
			line_q <= line_n;
			mode_q <= mode_n;
			coin_q <= coin_n;
		end
	end

endmodule

`default_nettype wire

>>> design/lcd_mode_line_timing.sv
// An item is captured in the input stage, stepped and held in the result register.
// One item per cycle unless the result output is stalled; the dot, line and mode
// update is a single add, a few compares and a subtract between the input and result registers.
// Reset (arst_n low, asynchronous) clears the counters, mode, coincidence
// flag, configuration registers and both stage valid bits.
`default_nettype none

module lcd_mode_line_timing
	import lmlt_pkg::*;
#(
	parameter int OAM_END       = DEF_OAM_END,
	parameter int TRANSFER_END  = DEF_TRANSFER_END,
	parameter int LINE_PERIOD   = DEF_LINE_PERIOD,
	parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
	parameter int LAST_LINE     = DEF_LAST_LINE
) (
	input wire logic clk,
	input wire logic arst_n,
	lmlt_item_if.sink     item,
	lmlt_result_if.source result,
	lmlt_cfg_if.sink      cfg
);

	logic             valid_s1;
	logic [CYC_W-1:0] cycles_s1;
	logic             enable_s1;
	logic             out_valid_q;
	lmlt_result_t     res_q;
	lmlt_result_t     res_n;
	lmlt_cfg_t        cfg_regs;
	logic             advance;
	logic             take;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	lmlt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	lmlt_step #(
		.OAM_END       (OAM_END),
		.TRANSFER_END  (TRANSFER_END),
		.LINE_PERIOD   (LINE_PERIOD),
		.VISIBLE_LINES (VISIBLE_LINES),
		.LAST_LINE     (LAST_LINE)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.cycles     (cycles_s1),
		.lcd_enable (enable_s1),
		.cfg        (cfg_regs),
		.result     (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cycles_s1 <= item.cycles;
			enable_s1 <= item.lcd_enable;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.mode         = res_q.mode;
	assign result.line         = res_q.line;
	assign result.coincidence  = res_q.coincidence;
	assign result.lcd_irq      = res_q.lcd_irq;
	assign result.vblank_irq   = res_q.vblank_irq;
	assign result.draw_request = res_q.draw_request;
	assign result.draw_index   = res_q.draw_index;

`ifndef SYNTHESIS
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register not loaded after a step");

	a_vblank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.vblank_irq) |-> (res_q.mode == MODE_VBLANK))
		else $error("vblank interrupt without vblank mode");

	a_draw_excl_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.draw_request && res_q.vblank_irq))
		else $error("draw and vblank in the same step");

	a_draw_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.draw_request) |-> (res_q.draw_index == '0))
		else $error("draw index nonzero without a draw request");
`endif

endmodule

`default_nettype wire
